@@ rtl/rso_pkg.sv @@
// Package for the rotation sine oscillator.
// Holds configuration codes, payload structs and output limits; no dependencies.
package rso_pkg;

  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned PhasorBits  = 32;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned ProdBits    = 2 * PhasorBits;
  localparam int unsigned AmpProdBits = PhasorBits + SampleBits;

  typedef enum logic [1:0] {
    REG_ROTATION_COS    = 2'd0,
    REG_ROTATION_SIN    = 2'd1,
    REG_AMPLITUDE_SCALE = 2'd2,
    REG_SAMPLE_COUNT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PhasorBits-1:0] rot_cos;
    logic signed [PhasorBits-1:0] rot_sin;
    logic signed [SampleBits-1:0] amp;
  } rot_cfg_t;

  typedef struct packed {
    logic signed [PhasorBits-1:0] re;
    logic signed [PhasorBits-1:0] im;
  } phasor_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_of_burst;
  } res_t;

  localparam logic signed [AmpProdBits-1:0] SampleMax = AmpProdBits'(32767);
  localparam logic signed [AmpProdBits-1:0] SampleMin = -AmpProdBits'(32768);

endpackage

@@ rtl/rso_if.sv @@
// Handshake channels of the rotation sine oscillator: input, result, configuration.
// Depends on rso_pkg.
interface rso_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rso_res_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample;
  logic        last_of_burst;

  modport source (output valid, output sample, output last_of_burst, input ready);
  modport sink (input valid, input sample, input last_of_burst, output ready);
endinterface

interface rso_cfg_if;
  logic              valid;
  logic              ready;
  rso_pkg::cfg_reg_e index;
  logic [31:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/rso_cfg_regs.sv @@
// Configuration register file of the rotation sine oscillator.
// Depends on rso_pkg.
module rso_cfg_regs #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  rso_pkg::cfg_reg_e             wr_index_i,
  input  logic [rso_pkg::CfgDataBits-1:0] wr_data_i,
  output rso_pkg::rot_cfg_t             rot_cfg_o,
  output logic [COUNT_BITS-1:0]         count_o
);
  import rso_pkg::*;

  localparam logic signed [PhasorBits-1:0] One = PhasorBits'(1) << FRAC_BITS;

  rot_cfg_t              rot_cfg_q;
  logic [COUNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cfg_q.rot_cos <= One;
      rot_cfg_q.rot_sin <= '0;
      rot_cfg_q.amp     <= SampleBits'(32767);
      count_q           <= '0;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        REG_ROTATION_COS:    rot_cfg_q.rot_cos <= wr_data_i[PhasorBits-1:0];
        REG_ROTATION_SIN:    rot_cfg_q.rot_sin <= wr_data_i[PhasorBits-1:0];
        REG_AMPLITUDE_SCALE: rot_cfg_q.amp     <= wr_data_i[SampleBits-1:0];
        REG_SAMPLE_COUNT:    count_q           <= wr_data_i[COUNT_BITS-1:0];
      endcase
    end
  end

  assign rot_cfg_o = rot_cfg_q;
  assign count_o   = count_q;

endmodule

@@ rtl/rso_datapath.sv @@
// Per-sample datapath: phasor rotation, scaled sample and burst bookkeeping.
// Depends on rso_pkg.
module rso_datapath #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 30
) (
  input  rso_pkg::rot_cfg_t     rot_cfg_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  rso_pkg::phasor_t      phasor_i,
  input  logic [COUNT_BITS-1:0] index_i,
  input  logic                  restart_i,
  output rso_pkg::phasor_t      phasor_o,
  output logic [COUNT_BITS-1:0] index_o,
  output rso_pkg::res_t         res_o,
  output logic                  has_res_o
);
  import rso_pkg::*;

  localparam logic signed [PhasorBits-1:0] One = PhasorBits'(1) << FRAC_BITS;
  localparam phasor_t PhasorReset = '{re: One, im: '0};

  phasor_t                        ph_cur;
  phasor_t                        ph_rot;
  logic [COUNT_BITS-1:0]          idx_cur;
  logic signed [ProdBits-1:0]     p_rc, p_is, p_rs, p_ic;
  logic        [ProdBits-1:0]     sum_re, sum_im;
  logic signed [AmpProdBits-1:0]  amp_prod, floor_q, trunc_q;
  logic                           round_up;
  logic signed [SampleBits-1:0]   sample_sat;
  logic                           last;

  assign ph_cur  = restart_i ? PhasorReset : phasor_i;
  assign idx_cur = restart_i ? '0 : index_i;

  assign p_rc = ph_cur.re * rot_cfg_i.rot_cos;
  assign p_is = ph_cur.im * rot_cfg_i.rot_sin;
  assign p_rs = ph_cur.re * rot_cfg_i.rot_sin;
  assign p_ic = ph_cur.im * rot_cfg_i.rot_cos;

  assign sum_re    = p_rc - p_is;
  assign sum_im    = p_rs + p_ic;
  assign ph_rot.re = sum_re[FRAC_BITS+PhasorBits-1:FRAC_BITS];
  assign ph_rot.im = sum_im[FRAC_BITS+PhasorBits-1:FRAC_BITS];

  assign amp_prod = rot_cfg_i.amp * ph_cur.im;
  assign floor_q  = amp_prod >>> FRAC_BITS;
  assign round_up = amp_prod[AmpProdBits-1] && (|amp_prod[FRAC_BITS-1:0]);
  assign trunc_q  = floor_q + AmpProdBits'(round_up);

  always_comb begin
    priority if (trunc_q > SampleMax) begin
      sample_sat = SampleMax[SampleBits-1:0];
    end else if (trunc_q < SampleMin) begin
      sample_sat = SampleMin[SampleBits-1:0];
    end else begin
      sample_sat = trunc_q[SampleBits-1:0];
    end
  end

  assign last      = idx_cur >= (count_i - COUNT_BITS'(1));
  assign res_o     = '{sample: sample_sat, last_of_burst: last};
  assign has_res_o = (count_i != '0);

  always_comb begin
    priority if (!has_res_o) begin
      phasor_o = ph_cur;
      index_o  = idx_cur;
    end else if (last) begin
      phasor_o = PhasorReset;
      index_o  = '0;
    end else begin
      phasor_o = ph_rot;
      index_o  = idx_cur + COUNT_BITS'(1);
    end
  end

endmodule

@@ rtl/rotation_sine_oscillator.sv @@
// Top level of the rotation sine oscillator: input register, datapath, result register.
// Depends on rso_pkg, rso_if, rso_cfg_regs and rso_datapath.
//
//   channel   role    payload                         transfer when
//   in_chan   sink    restart                         valid & ready
//   res_chan  source  sample, last_of_burst           valid & ready
//   cfg_chan  sink    index, data                     valid & ready (ready always high)
//
// One item per cycle unless stalled; a result passes the input and result registers.
// The phasor update (four 32x32 multiplies and two adds) is combinational.
// Reset loads the phasor with (1,0), clears the index and loads register defaults.
// A stalled result holds the result register; an empty input register still takes
// one more item, after which in_chan.ready drops until the result moves.
module rotation_sine_oscillator #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 30
) (
  input logic      clk_i,
  input logic      rst_ni,
  rso_in_if.sink   in_chan,
  rso_res_if.source res_chan,
  rso_cfg_if.sink  cfg_chan
);
  import rso_pkg::*;

  localparam logic signed [PhasorBits-1:0] One = PhasorBits'(1) << FRAC_BITS;

  rot_cfg_t              rot_cfg;
  logic [COUNT_BITS-1:0] count;

  logic                  in_v_q;
  logic                  in_restart_q;
  logic                  advance;
  logic                  in_ready;

  phasor_t               phasor_q, phasor_d;
  logic [COUNT_BITS-1:0] index_q, index_d;
  res_t                  res_d, res_q;
  logic                  has_res;
  logic                  out_v_q;

  assign cfg_chan.ready = 1'b1;

  rso_cfg_regs #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_chan.valid),
    .wr_index_i(cfg_chan.index),
    .wr_data_i (cfg_chan.data),
    .rot_cfg_o (rot_cfg),
    .count_o   (count)
  );

  rso_datapath #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .rot_cfg_i(rot_cfg),
    .count_i  (count),
    .phasor_i (phasor_q),
    .index_i  (index_q),
    .restart_i(in_restart_q),
    .phasor_o (phasor_d),
    .index_o  (index_d),
    .res_o    (res_d),
    .has_res_o(has_res)
  );

  assign advance       = in_v_q && (!out_v_q || res_chan.ready);
  assign in_ready      = !in_v_q || advance;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_chan.valid) begin
      in_restart_q <= in_chan.restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phasor_q.re <= One;
      phasor_q.im <= '0;
      index_q     <= '0;
    end else if (advance) begin
      phasor_q <= phasor_d;
      index_q  <= index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= has_res;
    end else if (res_chan.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_chan.valid         = out_v_q;
  assign res_chan.sample        = res_q.sample;
  assign res_chan.last_of_burst = res_q.last_of_burst;

endmodule

@@ rtl/rso_checker.sv @@
// Port-level checks for the rotation sine oscillator, bound to the top level.
// Depends on the top level's clock, reset and channel ports only.
module rso_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [15:0] sample_i,
  input logic              last_i
);

  logic burst_start_q;
  logic out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_start_q <= 1'b1;
    end else if (out_xfer) begin
      burst_start_q <= last_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_burst_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && burst_start_q |-> sample_i == 16'sd0)
    else $error("first sample of a burst is not zero");

endmodule

bind rotation_sine_oscillator rso_checker u_rso_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_chan.ready),
  .out_valid_i(res_chan.valid),
  .out_ready_i(res_chan.ready),
  .sample_i   (res_chan.sample),
  .last_i     (res_chan.last_of_burst)
);
